### hdl/sfu_pkg.sv
// Shared constants, register codes and helper functions for the spring force unit.
// No dependencies; every other file except sfu_sqrt refers to it by scoped names.
package sfu_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DP_MAX_W      = 32;   // widest word the datapath handles
   localparam int REG_W         = 31;   // width of both configuration registers
   localparam int CSR_INDEX_W   = 2;

   localparam logic [REG_W-1:0] SPRING_CONSTANT_RESET = 31'd65536;
   localparam logic [REG_W-1:0] REST_LENGTH_RESET     = 31'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPRING_CONSTANT = 2'd0,
      CSR_REST_LENGTH     = 2'd1
   } csr_index_type;

   // Effective datapath word: wider words are clamped to DP_MAX_W bits.
   function automatic int eff_bits(input int word_bits);
      return (word_bits > DP_MAX_W) ? DP_MAX_W : word_bits;
   endfunction

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

### hdl/sfu_req_if.sv
// Request channel of the spring force unit: two attachment points per transaction.
// Depends on sfu_pkg for the default word width.
interface sfu_req_if #(
   parameter int WORD_BITS = sfu_pkg::WORD_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] end_a_x;
   logic [WORD_BITS-1:0] end_a_y;
   logic [WORD_BITS-1:0] end_a_z;
   logic [WORD_BITS-1:0] end_b_x;
   logic [WORD_BITS-1:0] end_b_y;
   logic [WORD_BITS-1:0] end_b_z;

   modport source (
      output valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
      input  ready
   );
   modport sink (
      input  valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
      output ready
   );
endinterface

### hdl/sfu_rsp_if.sv
// Response channel of the spring force unit: force vector and status flags.
// Depends on sfu_pkg for the default word width.
interface sfu_rsp_if #(
   parameter int WORD_BITS = sfu_pkg::WORD_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] force_x;
   logic [WORD_BITS-1:0] force_y;
   logic [WORD_BITS-1:0] force_z;
   logic                 zero_length;
   logic                 saturated;

   modport source (
      output valid, force_x, force_y, force_z, zero_length, saturated,
      input  ready
   );
   modport sink (
      input  valid, force_x, force_y, force_z, zero_length, saturated,
      output ready
   );
endinterface

### hdl/sfu_front.sv
// Front end: difference vector, component magnitudes, squares and their sum.
// Four register stages; depends on sfu_pkg.
module sfu_front #(
   parameter  int WORD_BITS = sfu_pkg::WORD_BITS_DEF,
   localparam int EFF       = sfu_pkg::eff_bits(WORD_BITS),
   localparam int MAG_W     = EFF + 1,
   localparam int SUM_W     = 2 * MAG_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [WORD_BITS-1:0] end_a [3],
   input  logic [WORD_BITS-1:0] end_b [3],
   output logic                 out_valid,
   output logic [SUM_W-1:0]     sum,
   output logic [MAG_W-1:0]     mag [3],
   output logic [2:0]           neg,
   output logic                 zero
);

   logic signed [MAG_W-1:0] diff_in [3];
   logic signed [MAG_W-1:0] diff_ff [3];
   logic [MAG_W-1:0]        mag1_in [3];
   logic [MAG_W-1:0]        mag1_ff [3];
   logic [MAG_W-1:0]        mag2_ff [3];
   logic [MAG_W-1:0]        mag3_ff [3];
   logic [2:0]              neg1_ff, neg2_ff, neg3_ff;
   logic [SUM_W-1:0]        sq_in [3];
   logic [SUM_W-1:0]        sq_ff [3];
   logic [SUM_W-1:0]        sum_in, sum_ff;
   logic                    zero_in, zero2_ff, zero3_ff;
   logic [3:0]              valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = $signed({end_a[i][EFF-1], end_a[i][EFF-1:0]})
                    - $signed({end_b[i][EFF-1], end_b[i][EFF-1:0]});
         mag1_in[i] = diff_ff[i][MAG_W-1] ? MAG_W'(-diff_ff[i]) : MAG_W'(diff_ff[i]);
         sq_in[i]   = SUM_W'(mag1_ff[i]) * SUM_W'(mag1_ff[i]);
      end
      sum_in  = sq_ff[0] + sq_ff[1] + sq_ff[2];
      zero_in = (mag1_ff[0] == '0) && (mag1_ff[1] == '0) && (mag1_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= diff_in[i];
            mag1_ff[i] <= mag1_in[i];
            neg1_ff[i] <= diff_ff[i][MAG_W-1];
            sq_ff[i]   <= sq_in[i];
            mag2_ff[i] <= mag1_ff[i];
            mag3_ff[i] <= mag2_ff[i];
         end
         neg2_ff  <= neg1_ff;
         neg3_ff  <= neg2_ff;
         zero2_ff <= zero_in;
         zero3_ff <= zero2_ff;
         sum_ff   <= sum_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign sum       = sum_ff;
   assign mag       = mag3_ff;
   assign neg       = neg3_ff;
   assign zero      = zero3_ff;

endmodule

### hdl/sfu_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word alongside; depends on nothing else.
module sfu_sqrt #(
   parameter  int RAD_W  = 66,
   parameter  int SIDE_W = 1,
   localparam int ROOT_W = RAD_W / 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] root,
   output logic [SIDE_W-1:0] out_side
);

   logic [RAD_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];
   logic              valid_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [RAD_W-1:0]  rem_cur, trial;
      logic [ROOT_W-1:0] root_cur;
      logic [SIDE_W-1:0] side_cur;
      logic              valid_cur, fits;

      if (k == 0) begin : g_first
         assign rem_cur   = rad;
         assign root_cur  = '0;
         assign side_cur  = in_side;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rem_cur   = rem_ff[k-1];
         assign root_cur  = root_ff[k-1];
         assign side_cur  = side_ff[k-1];
         assign valid_cur = valid_ff[k-1];
      end

      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
      assign trial = (RAD_W'(root_cur) << (B + 1)) | (RAD_W'(1) << (2 * B));
      assign fits  = (rem_cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= fits ? (rem_cur - trial) : rem_cur;
            root_ff[k] <= fits ? (root_cur | (ROOT_W'(1) << B)) : root_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

### hdl/sfu_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
// Carries a sideband word alongside; depends on sfu_pkg.
module sfu_div #(
   parameter  int NUM_W  = 49,
   parameter  int DEN_W  = 33,
   parameter  int QUO_W  = 17,
   parameter  int SIDE_W = 1,
   parameter  int LANES  = 3,
   localparam int CMP_W  = sfu_pkg::max_int(NUM_W, DEN_W + QUO_W)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num [LANES],
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quo [LANES],
   output logic [SIDE_W-1:0] out_side
);

   logic [NUM_W-1:0]  rem_ff   [QUO_W][LANES];
   logic [QUO_W-1:0]  quo_ff   [QUO_W][LANES];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];
   logic              valid_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int B = QUO_W - 1 - k;
      logic [NUM_W-1:0]  rem_cur [LANES];
      logic [QUO_W-1:0]  quo_cur [LANES];
      logic [NUM_W-1:0]  rem_in  [LANES];
      logic [QUO_W-1:0]  quo_in  [LANES];
      logic [DEN_W-1:0]  den_cur;
      logic [SIDE_W-1:0] side_cur;
      logic              valid_cur;
      logic [CMP_W-1:0]  shifted;

      if (k == 0) begin : g_first
         assign rem_cur   = num;
         for (genvar l = 0; l < LANES; l++) begin : g_clr
            assign quo_cur[l] = '0;
         end
         assign den_cur   = den;
         assign side_cur  = in_side;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rem_cur   = rem_ff[k-1];
         assign quo_cur   = quo_ff[k-1];
         assign den_cur   = den_ff[k-1];
         assign side_cur  = side_ff[k-1];
         assign valid_cur = valid_ff[k-1];
      end

      assign shifted = CMP_W'(den_cur) << B;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (CMP_W'(rem_cur[l]) >= shifted) begin
               rem_in[l] = NUM_W'(CMP_W'(rem_cur[l]) - shifted);
               quo_in[l] = quo_cur[l] | (QUO_W'(1) << B);
            end else begin
               rem_in[l] = rem_cur[l];
               quo_in[l] = quo_cur[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

### hdl/sfu_back.sv
// Back end: spring magnitude, per-axis scaling, sign and saturation, output register.
// Three register stages; depends on sfu_pkg.
module sfu_back #(
   parameter  int WORD_BITS = sfu_pkg::WORD_BITS_DEF,
   parameter  int FRAC_BITS = sfu_pkg::FRAC_BITS_DEF,
   parameter  int QUO_W     = FRAC_BITS + 1,
   parameter  int EMAG_W    = 34,
   localparam int EFF       = sfu_pkg::eff_bits(WORD_BITS),
   localparam int KP_W      = sfu_pkg::REG_W + EMAG_W,
   localparam int MM_W      = KP_W - FRAC_BITS,
   localparam int FP_W      = QUO_W + MM_W,
   localparam int PR_W      = FP_W - FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [QUO_W-1:0]          quo [3],
   input  logic [EMAG_W-1:0]         emag,
   input  logic                      eneg,
   input  logic [2:0]                neg,
   input  logic                      zero,
   input  logic [sfu_pkg::REG_W-1:0] spring_constant,
   output logic                      out_valid,
   output logic [WORD_BITS-1:0]      force_out [3],
   output logic                      zero_length,
   output logic                      saturated
);

   localparam logic [PR_W-1:0] LIM_POS = PR_W'((64'd1 << (EFF - 1)) - 64'd1);
   localparam logic [PR_W-1:0] LIM_NEG = PR_W'(64'd1 << (EFF - 1));

   logic [KP_W-1:0]      kprod;
   logic [MM_W-1:0]      mmag_ff;
   logic [QUO_W-1:0]     quo1_ff [3];
   logic [2:0]           neg1_ff;
   logic                 eneg1_ff, zero1_ff, zero2_ff;
   logic [FP_W-1:0]      fprod [3];
   logic [PR_W-1:0]      fmag_ff [3];
   logic [2:0]           fneg_ff;
   logic [PR_W-1:0]      limit [3];
   logic [PR_W-1:0]      clip [3];
   logic [EFF-1:0]       signed_val [3];
   logic [WORD_BITS-1:0] force_in [3];
   logic [WORD_BITS-1:0] force_ff [3];
   logic [2:0]           over;
   logic                 sat_in, sat_ff, zero_ff;
   logic [2:0]           valid_ff;

   always_comb begin
      kprod = KP_W'(spring_constant) * KP_W'(emag);
      for (int i = 0; i < 3; i++) begin
         fprod[i]      = FP_W'(quo1_ff[i]) * FP_W'(mmag_ff);
         limit[i]      = fneg_ff[i] ? LIM_NEG : LIM_POS;
         over[i]       = fmag_ff[i] > limit[i];
         clip[i]       = over[i] ? limit[i] : fmag_ff[i];
         signed_val[i] = fneg_ff[i] ? EFF'(-clip[i]) : EFF'(clip[i]);
         force_in[i]   = zero2_ff ? '0 : WORD_BITS'(signed_val[i]);
      end
      sat_in = !zero2_ff && (over != 3'b000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // magnitude |M| = k*|e| >> FRAC_BITS
         mmag_ff  <= kprod[KP_W-1:FRAC_BITS];
         quo1_ff  <= quo;
         neg1_ff  <= neg;
         eneg1_ff <= eneg;
         zero1_ff <= zero;
         for (int i = 0; i < 3; i++) begin
            fmag_ff[i] <= fprod[i][FP_W-1:FRAC_BITS];
            fneg_ff[i] <= (neg1_ff[i] == eneg1_ff);
         end
         zero2_ff <= zero1_ff;
         force_ff <= force_in;
         sat_ff   <= sat_in;
         zero_ff  <= zero2_ff;
      end
   end

   assign out_valid   = valid_ff[2];
   assign force_out   = force_ff;
   assign zero_length = zero_ff;
   assign saturated   = sat_ff;

endmodule

### hdl/spring_force_unit_core.sv
// Top level of the spring force unit: channels, configuration registers, pipeline glue.
// Depends on sfu_pkg, sfu_req_if, sfu_rsp_if, sfu_front, sfu_sqrt, sfu_div, sfu_back.
//
// Use: each req transaction carries the world points of a spring's two ends, A on
// this body and B on the other; each rsp transaction returns the Hooke force on
// the first body, signed fixed point with FRAC_BITS fraction bits, every axis
// clipped to the word range, plus zero_length (ends coincide, force zero) and
// saturated (an axis was clipped). One rsp per req, in order.
// Throughput: one transaction per cycle, sustained while rsp.ready stays high.
// Pipeline: from acceptance to rsp.valid a transaction passes the front, square
// root, length, divider and back stages in that order, where EFF is WORD_BITS
// clamped to 32. The square root takes EFF + 1 stages and the three-lane divider
// FRAC_BITS + 1 stages, one bit a stage; the rest is four front stages, one length stage and three back stages.
// Stall: every stage advances together; while rsp.valid is high and rsp.ready low
// the whole pipeline holds and req.ready drops, so nothing is lost or repeated.
// Reset (synchronous, active high) clears every valid bit, sets spring_constant
// to 1.0 and rest_length to 0. Write csr_* only while no transaction is in flight.
module spring_force_unit_core #(
   parameter int WORD_BITS = sfu_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = sfu_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   sfu_req_if.sink                         req,
   sfu_rsp_if.source                       rsp,
   input  logic                            csr_write,
   input  logic [sfu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfu_pkg::REG_W-1:0]       csr_wdata
);

   localparam int EFF     = sfu_pkg::eff_bits(WORD_BITS);
   localparam int MAG_W   = EFF + 1;
   localparam int SUM_W   = 2 * MAG_W;
   localparam int LEN_W   = MAG_W;
   localparam int EMAG_W  = sfu_pkg::max_int(LEN_W, sfu_pkg::REG_W);
   localparam int QUO_W   = FRAC_BITS + 1;
   localparam int NUM_W   = MAG_W + FRAC_BITS;
   localparam int SQ_SIDE = 3 * MAG_W + 4;
   localparam int DV_SIDE = EMAG_W + 5;

   localparam logic [WORD_BITS-1:0] F_MAX = WORD_BITS'((64'd1 << (EFF - 1)) - 64'd1);
   localparam logic [WORD_BITS-1:0] F_MIN = WORD_BITS'(64'd1 << (EFF - 1));

   // configuration
   logic [sfu_pkg::REG_W-1:0] spring_constant_ff;
   logic [sfu_pkg::REG_W-1:0] rest_length_ff;

   // pipeline advance: hold everything while a finished result waits
   logic                 en;
   logic                 out_valid;

   logic [WORD_BITS-1:0] end_a [3];
   logic [WORD_BITS-1:0] end_b [3];

   logic                 fr_valid;
   logic [SUM_W-1:0]     fr_sum;
   logic [MAG_W-1:0]     fr_mag [3];
   logic [2:0]           fr_neg;
   logic                 fr_zero;

   logic                 sq_valid;
   logic [LEN_W-1:0]     sq_root;
   logic [SQ_SIDE-1:0]   sq_side;

   logic signed [EMAG_W:0] e_in;
   logic [EMAG_W-1:0]    emag_in;
   logic [LEN_W-1:0]     len_ff;
   logic [EMAG_W-1:0]    emag_ff;
   logic                 eneg_ff;
   logic [SQ_SIDE-1:0]   pass_ff;
   logic                 len_valid_ff;

   logic [NUM_W-1:0]     dv_num [3];
   logic [DV_SIDE-1:0]   dv_side_in;
   logic                 dv_valid;
   logic [QUO_W-1:0]     dv_quo [3];
   logic [DV_SIDE-1:0]   dv_side;

   logic [WORD_BITS-1:0] force_out [3];

   // --- configuration port: writes beyond the register list drop silently
   always_ff @(posedge clock) begin
      if (reset) begin
         spring_constant_ff <= sfu_pkg::SPRING_CONSTANT_RESET;
         rest_length_ff     <= sfu_pkg::REST_LENGTH_RESET;
      end else if (csr_write) begin
         case (sfu_pkg::csr_index_type'(csr_index))
            sfu_pkg::CSR_SPRING_CONSTANT: spring_constant_ff <= csr_wdata;
            sfu_pkg::CSR_REST_LENGTH:     rest_length_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = !out_valid || rsp.ready;
   assign req.ready = en;

   assign end_a[0] = req.end_a_x;
   assign end_a[1] = req.end_a_y;
   assign end_a[2] = req.end_a_z;
   assign end_b[0] = req.end_b_x;
   assign end_b[1] = req.end_b_y;
   assign end_b[2] = req.end_b_z;

   // --- difference vector, magnitudes and squared length
   sfu_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .end_a     (end_a),
      .end_b     (end_b),
      .out_valid (fr_valid),
      .sum       (fr_sum),
      .mag       (fr_mag),
      .neg       (fr_neg),
      .zero      (fr_zero)
   );

   // --- length: the magnitudes and signs ride along as sideband
   sfu_sqrt #(.RAD_W(SUM_W), .SIDE_W(SQ_SIDE)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .rad       (fr_sum),
      .in_side   ({fr_zero, fr_neg, fr_mag[2], fr_mag[1], fr_mag[0]}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   // --- extension e = L - rest, split into magnitude and sign
   always_comb begin
      e_in    = $signed({1'b0, EMAG_W'(sq_root)}) - $signed({1'b0, EMAG_W'(rest_length_ff)});
      emag_in = e_in[EMAG_W] ? EMAG_W'(-e_in) : EMAG_W'(e_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= 1'b0;
      end else if (en) begin
         len_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff  <= sq_root;
         emag_ff <= emag_in;
         eneg_ff <= e_in[EMAG_W];
         pass_ff <= sq_side;
      end
   end

   // --- unit direction |d_i| / L, one quotient bit a stage
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_num[i] = {pass_ff[i*MAG_W +: MAG_W], FRAC_BITS'(0)};
      end
      dv_side_in = {pass_ff[SQ_SIDE-1], pass_ff[3*MAG_W +: 3], eneg_ff, emag_ff};
   end

   sfu_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (LEN_W),
      .QUO_W  (QUO_W),
      .SIDE_W (DV_SIDE),
      .LANES  (3)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (len_valid_ff),
      .num       (dv_num),
      .den       (len_ff),
      .in_side   (dv_side_in),
      .out_valid (dv_valid),
      .quo       (dv_quo),
      .out_side  (dv_side)
   );

   // --- magnitude, scaling, sign and clipping; last stage is the output register
   sfu_back #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .QUO_W     (QUO_W),
      .EMAG_W    (EMAG_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (dv_valid),
      .quo             (dv_quo),
      .emag            (dv_side[EMAG_W-1:0]),
      .eneg            (dv_side[EMAG_W]),
      .neg             (dv_side[EMAG_W+3:EMAG_W+1]),
      .zero            (dv_side[DV_SIDE-1]),
      .spring_constant (spring_constant_ff),
      .out_valid       (out_valid),
      .force_out       (force_out),
      .zero_length     (rsp.zero_length),
      .saturated       (rsp.saturated)
   );

   assign rsp.valid   = out_valid;
   assign rsp.force_x = force_out[0];
   assign rsp.force_y = force_out[1];
   assign rsp.force_z = force_out[2];

   // --- checks
   a_zero_len_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid && rsp.zero_length |->
         rsp.force_x == '0 && rsp.force_y == '0 && rsp.force_z == '0 && !rsp.saturated)
      else $error("zero-length result carries force or saturation");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      out_valid && rsp.saturated |->
         rsp.force_x == F_MAX || rsp.force_x == F_MIN ||
         rsp.force_y == F_MAX || rsp.force_y == F_MIN ||
         rsp.force_z == F_MAX || rsp.force_z == F_MIN)
      else $error("saturated flag without a clipped component");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !out_valid)
      else $error("result valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && !rsp.ready |=> out_valid && $stable(force_out[0]))
      else $error("stalled result changed");

endmodule
